// ===== hw/rtl/tse_pkg.sv =====
// Shared constants, codes and controller/datapath link types for the tread speed equalizer.
`timescale 1ns / 1ps

package tse_pkg;

   // Default timer width of the edge capture values
   localparam int TIMER_BITS_DEF = 16;

   // Configuration port geometry
   localparam int CSR_WIDTH      = 15;
   localparam int CSR_INDEX_BITS = 2;

   // Register reset values
   localparam logic [CSR_WIDTH-1:0] DESIRED_RESET = 15'd2500;
   localparam logic [CSR_WIDTH-1:0] DIVISOR_RESET = 15'h007F;

   // Duty and correction bounds
   localparam logic [7:0] DUTY_RESET = 8'hF0;
   localparam logic [7:0] DUTY_MAX   = 8'hFF;
   localparam logic [7:0] CORR_MAX   = 8'sd127;
   localparam logic [7:0] CORR_MIN   = 8'h80;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DESIRED   = 2'd0,
      REG_LEFT_DIV  = 2'd1,
      REG_RIGHT_DIV = 2'd2
   } csr_index_type;

   // Input opcodes
   typedef enum logic {
      OP_START = 1'b0,
      OP_EDGE  = 1'b1
   } opcode_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take;      // input side open for a transfer
      logic div_start; // load the divider from the accepted edge
      logic div_step;  // one restoring divide step
      logic apply;     // update duty and load the result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic need_div;  // transfer this cycle is a non-first edge
      logic out_busy;  // result register still holds an untaken result
   } status_type;

endpackage

// ===== hw/rtl/tse_if.sv =====
// Valid/ready channel interfaces for the edge capture input and the duty update result.
`timescale 1ns / 1ps

interface tse_req_if #(
   parameter int TIMER_BITS = tse_pkg::TIMER_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic                  tread;
   logic [TIMER_BITS-1:0] edge_time;

   modport source (output valid, output opcode, output tread, output edge_time, input ready);
   modport sink   (input valid, input opcode, input tread, input edge_time, output ready);
endinterface

interface tse_rsp_if;
   logic              valid;
   logic              ready;
   logic              tread_res;
   logic        [7:0] duty;
   logic signed [7:0] correction;

   modport source (output valid, output tread_res, output duty, output correction, input ready);
   modport sink   (input valid, input tread_res, input duty, input correction, output ready);
endinterface

// ===== hw/rtl/tse_ctrl.sv =====
// Controller state machine: accept, divide sequencing and result hand-off.
`timescale 1ns / 1ps

module tse_ctrl #(
   parameter int TIMER_BITS = tse_pkg::TIMER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tse_pkg::status_type  status,
   output tse_pkg::cmd_type     cmd
);
   import tse_pkg::*;

   localparam int ERR_BITS = ((TIMER_BITS > CSR_WIDTH) ? TIMER_BITS : CSR_WIDTH) + 1;
   localparam int CNT_BITS = $clog2(ERR_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV   = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               count_in      = CNT_BITS'(ERR_BITS);
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff - CNT_BITS'(1);
            if (count_ff == CNT_BITS'(1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // hold until the result register can take the new result
            if (!status.out_busy) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/tse_datapath.sv =====
// Datapath: tread state, configuration registers, restoring divider and result register.
`timescale 1ns / 1ps

module tse_datapath #(
   parameter int TIMER_BITS = tse_pkg::TIMER_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [tse_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tse_pkg::CSR_WIDTH-1:0]         csr_wdata,
   tse_req_if.sink                               req_chan,
   tse_rsp_if.source                             rsp_chan,
   input  tse_pkg::cmd_type                      cmd,
   output tse_pkg::status_type                   status
);
   import tse_pkg::*;

   localparam int ERR_BITS = ((TIMER_BITS > CSR_WIDTH) ? TIMER_BITS : CSR_WIDTH) + 1;
   localparam int REM_BITS = CSR_WIDTH + 1;

   // Configuration registers
   logic [CSR_WIDTH-1:0]  desired_ff;
   logic [CSR_WIDTH-1:0]  left_div_ff;
   logic [CSR_WIDTH-1:0]  right_div_ff;

   // Per-tread state
   logic [1:0]            awaiting_ff;
   logic [TIMER_BITS-1:0] prev_edge_ff [2];
   logic [7:0]            duty_ff [2];

   // Divider state
   logic [ERR_BITS-1:0]   quo_ff, quo_in;
   logic [CSR_WIDTH-1:0]  rem_ff, rem_in;
   logic [CSR_WIDTH-1:0]  div_ff;
   logic                  neg_ff;
   logic                  tread_ff;

   // Result register
   logic                  out_valid_ff;
   logic                  out_tread_ff;
   logic [7:0]            out_duty_ff;
   logic [7:0]            out_corr_ff;

   logic                  accept;
   logic [TIMER_BITS-1:0] period;
   logic [ERR_BITS-1:0]   error;
   logic [ERR_BITS-1:0]   mag;
   logic [CSR_WIDTH-1:0]  div_sel;
   logic [REM_BITS-1:0]   trial;
   logic                  fits;
   logic                  big;
   logic [7:0]            low_mag;
   logic [7:0]            corr;
   logic signed [9:0]     sum;
   logic [7:0]            duty_new;

   assign req_chan.ready = cmd.take;
   assign accept         = req_chan.valid && cmd.take;

   assign status.need_div = accept && (req_chan.opcode == OP_EDGE)
                            && !awaiting_ff[req_chan.tread];
   assign status.out_busy = out_valid_ff && !rsp_chan.ready;

   // Error magnitude and sign of the accepted edge
   always_comb begin
      period  = req_chan.edge_time - prev_edge_ff[req_chan.tread];
      error   = {1'b0, (ERR_BITS-1)'(period)} - {1'b0, (ERR_BITS-1)'(desired_ff)};
      mag     = error[ERR_BITS-1] ? (~error + ERR_BITS'(1)) : error;
      div_sel = req_chan.tread ? right_div_ff : left_div_ff;
   end

   // One restoring divide step; the remainder stays below the divisor
   always_comb begin
      trial  = {rem_ff, quo_ff[ERR_BITS-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? CSR_WIDTH'(trial - {1'b0, div_ff}) : trial[CSR_WIDTH-1:0];
      quo_in = {quo_ff[ERR_BITS-2:0], fits};
   end

   // Saturate the quotient and clamp the new duty
   always_comb begin
      big     = |quo_ff[ERR_BITS-1:7];
      low_mag = {1'b0, quo_ff[6:0]};
      if (neg_ff) begin
         corr = big ? CORR_MIN : (~low_mag + 8'd1);
      end else begin
         corr = big ? CORR_MAX : low_mag;
      end
      sum = $signed({2'b00, duty_ff[tread_ff]}) + $signed({{2{corr[7]}}, corr});
      if (sum[9]) begin
         duty_new = 8'd0;
      end else if (sum[8]) begin
         duty_new = DUTY_MAX;
      end else begin
         duty_new = sum[7:0];
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff   <= DESIRED_RESET;
         left_div_ff  <= DIVISOR_RESET;
         right_div_ff <= DIVISOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DESIRED:   desired_ff   <= csr_wdata;
            REG_LEFT_DIV:  left_div_ff  <= csr_wdata;
            REG_RIGHT_DIV: right_div_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // First-edge flags and duties
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 2'b11;
         duty_ff[0]  <= DUTY_RESET;
         duty_ff[1]  <= DUTY_RESET;
      end else begin
         if (accept) begin
            if (req_chan.opcode == OP_START) begin
               awaiting_ff <= 2'b11;
            end else begin
               awaiting_ff[req_chan.tread] <= 1'b0;
            end
         end
         if (cmd.apply) begin
            duty_ff[tread_ff] <= duty_new;
         end
      end
   end

   // Edge times and divider registers
   always_ff @(posedge clock) begin
      if (accept && (req_chan.opcode == OP_EDGE)) begin
         prev_edge_ff[req_chan.tread] <= req_chan.edge_time;
      end
      if (cmd.div_start) begin
         quo_ff   <= mag;
         rem_ff   <= '0;
         div_ff   <= (div_sel == '0) ? CSR_WIDTH'(1) : div_sel;
         neg_ff   <= error[ERR_BITS-1];
         tread_ff <= req_chan.tread;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Result register: load on apply, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         out_tread_ff <= tread_ff;
         out_duty_ff  <= duty_new;
         out_corr_ff  <= corr;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.tread_res  = out_tread_ff;
   assign rsp_chan.duty       = out_duty_ff;
   assign rsp_chan.correction = $signed(out_corr_ff);

endmodule

// ===== hw/rtl/tread_speed_equalizer.sv =====
// Top level of the tread speed equalizer: controller and datapath.
//
//   channel    direction  handshake            payload
//   req_chan   in         valid/ready          opcode, tread, edge_time
//   rsp_chan   out        valid/ready          tread_res, duty, correction
//   csr_*      in         csr_we, no wait      csr_index, csr_wdata
//
// A start item or a first edge is done once accepted. A later edge is accepted,
// then divided in the restoring divider, one quotient bit per step, and then
// its duty is applied.
// Reset is synchronous and active high; duties return to 240.
// A result waits in the output register; the next item is accepted meanwhile,
// and only the apply step stalls while an earlier result is not yet taken.
`timescale 1ns / 1ps

module tread_speed_equalizer #(
   parameter int TIMER_BITS = tse_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tse_pkg::CSR_WIDTH-1:0]       csr_wdata,
   tse_req_if.sink                             req_chan,
   tse_rsp_if.source                           rsp_chan
);
   import tse_pkg::*;

   cmd_type    cmd;
   status_type status;

   tse_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tse_datapath #(
      .TIMER_BITS (TIMER_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== tb/tread_speed_equalizer_tb.sv =====
// Self-checking testbench for the tread speed equalizer: driver, monitor and duty predictor.
`timescale 1ns / 1ps

module tread_speed_equalizer_tb;
   import tse_pkg::*;

   localparam int TIMER_BITS   = TIMER_BITS_DEF;
   localparam int LIMIT_CYCLES = 500000;
   localparam int SETTLE       = 40;   // settle time after draining, longer than an edge update takes
   localparam int PHASE_ITEMS  = 190;

   typedef struct {
      opcode_type            opcode;
      logic                  tread;
      logic [TIMER_BITS-1:0] edge_time;
      bit                    drain_first;   // hold off until every duty update is back
   } capture_type;

   typedef struct {
      logic       tread;
      logic [7:0] duty;
      logic [7:0] correction;
   } duty_update_type;

   logic clock;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_WIDTH-1:0]      csr_wdata;

   tse_req_if #(.TIMER_BITS(TIMER_BITS)) req_chan ();
   tse_rsp_if rsp_chan ();

   tread_speed_equalizer #(.TIMER_BITS(TIMER_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Stimulus and expectations
   capture_type     capture_queue[$];
   duty_update_type duty_updates[$];
   int              error_count;

   // Predictor state and its copy of the registers
   int                    target_period;
   int                    left_div;
   int                    right_div;
   bit                    first_pending [2];
   logic [TIMER_BITS-1:0] last_capture  [2];
   logic [7:0]            duty_now      [2];

   // Generator's running timer per tread
   int gen_last [2];

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75)
         return $urandom_range(1, 3);
      else if (roll < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Work out the duty update caused by one accepted capture
   task automatic compute_duty_update(opcode_type op, logic tr, logic [TIMER_BITS-1:0] et);
      logic [TIMER_BITS-1:0] period;
      int                    err;
      int                    dv;
      int                    corr;
      int                    level;
      duty_update_type       upd;
      if (op == OP_START) begin
         first_pending[0] = 1'b1;
         first_pending[1] = 1'b1;
         return;
      end
      if (first_pending[tr]) begin
         last_capture[tr]  = et;
         first_pending[tr] = 1'b0;
         return;
      end
      period           = et - last_capture[tr];
      last_capture[tr] = et;
      err              = int'(period);
      err              = err - target_period;
      dv               = tr ? right_div : left_div;
      if (dv == 0)
         dv = 1;
      // integer division truncates toward zero
      corr = err / dv;
      if (corr > 127)
         corr = 127;
      else if (corr < -128)
         corr = -128;
      level = int'(duty_now[tr]);
      level = level + corr;
      if (level > 255)
         level = 255;
      else if (level < 0)
         level = 0;
      duty_now[tr]   = level[7:0];
      upd.tread      = tr;
      upd.duty       = level[7:0];
      upd.correction = corr[7:0];
      duty_updates.push_back(upd);
   endtask

   // Drive the capture channel from the pending queue
   int  send_gap;
   int  send_cycles;
   always @(posedge clock) begin
      capture_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap    = 0;
         send_cycles = 0;
      end else begin
         send_cycles++;
         if (req_chan.valid && req_chan.ready)
            compute_duty_update(opcode_type'(req_chan.opcode), req_chan.tread,
                                req_chan.edge_time);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (capture_queue.size() != 0 &&
                         !(capture_queue[0].drain_first && duty_updates.size() != 0)) begin
               nxt = capture_queue.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.opcode    <= nxt.opcode;
               req_chan.tread     <= nxt.tread;
               req_chan.edge_time <= nxt.edge_time;
               // quiet stretches keep the channel busy back to back
               if (((send_cycles >> 8) % 5) == 0)
                  send_gap = 0;
               else if ($urandom_range(0, 2) == 0)
                  send_gap = pick_gap();
               else
                  send_gap = 0;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Drive result ready: random stalls plus long hold-offs that back up the block
   int rsp_stall;
   int rsp_taken;
   int rsp_cycles;
   int long_hold_at;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall    = 0;
         rsp_taken    = 0;
         rsp_cycles   = 0;
         long_hold_at = 150;
      end else begin
         rsp_cycles++;
         if (rsp_chan.valid && rsp_chan.ready)
            rsp_taken++;
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_taken == long_hold_at) begin
            rsp_stall    = 300;
            long_hold_at = long_hold_at + 350;
            rsp_chan.ready <= 1'b0;
         end else if (((rsp_cycles >> 7) % 6) == 1) begin
            rsp_chan.ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall = pick_gap() - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      duty_update_type exp_upd;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (duty_updates.size() == 0) begin
            report_mismatch($sformatf("unexpected result tread %0d duty %0d corr %0d",
                            rsp_chan.tread_res, rsp_chan.duty, rsp_chan.correction));
         end else begin
            exp_upd = duty_updates.pop_front();
            if (rsp_chan.tread_res !== exp_upd.tread)
               report_mismatch($sformatf("tread_res %0d, expected %0d",
                               rsp_chan.tread_res, exp_upd.tread));
            if (rsp_chan.duty !== exp_upd.duty)
               report_mismatch($sformatf("duty %0d, expected %0d (tread %0d)",
                               rsp_chan.duty, exp_upd.duty, exp_upd.tread));
            if (rsp_chan.correction !== exp_upd.correction)
               report_mismatch($sformatf("correction %0d, expected %0d (tread %0d)",
                               rsp_chan.correction, $signed(exp_upd.correction),
                               exp_upd.tread));
         end
      end
   end

   // Watchdog
   int run_cycles;
   always @(posedge clock) begin
      run_cycles++;
      if (run_cycles >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Write all three registers, one per cycle, while the block is idle
   task automatic write_config(int desired, int left, int right);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_DESIRED;
      csr_wdata <= desired[CSR_WIDTH-1:0];
      @(posedge clock);
      csr_index <= REG_LEFT_DIV;
      csr_wdata <= left[CSR_WIDTH-1:0];
      @(posedge clock);
      csr_index <= REG_RIGHT_DIV;
      csr_wdata <= right[CSR_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      target_period = desired;
      left_div      = left;
      right_div     = right;
   endtask

   // Wait until every capture is taken and every update is back, then let the block settle
   task automatic wait_drained();
      while (capture_queue.size() != 0 || req_chan.valid || duty_updates.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic capture_type make_capture(opcode_type op, logic tr,
                                                logic [TIMER_BITS-1:0] et);
      capture_type c;
      c.opcode      = op;
      c.tread       = tr;
      c.edge_time   = et;
      c.drain_first = 1'b0;
      return c;
   endfunction

   // Directed captures under the reset settings
   task automatic queue_directed();
      @(negedge clock);
      capture_queue.push_back(make_capture(OP_START, 1'b0, 16'h0000));
      // first edge, exact period, full wrap to saturation, zero period
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'h0000));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'd2500));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'd2499));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'd2499));
      // right tread: wrap across the timer top, then a long period
      capture_queue.push_back(make_capture(OP_EDGE, 1'b1, 16'hFFFF));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b1, 16'h0000));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b1, 16'h7FFF));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b1, 16'h7FFF + 16'd2500 + 16'd635));
      // start with nonzero fields: they are ignored, flags return
      capture_queue.push_back(make_capture(OP_START, 1'b1, 16'hFFFF));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b1, 16'h1234));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'h8000));
      // truncation toward zero around one divisor step
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'h8000 + 16'd2627));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'h8000 + 16'd2627 + 16'd2374));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0,
                                           16'h8000 + 16'd2627 + 16'd2374 + 16'd2373));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b1, 16'h1234 + 16'd2500));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b1, 16'hAAAA));
      capture_queue.push_back(make_capture(OP_EDGE, 1'b0, 16'h5555));
      gen_last[0] = 'h5555;
      gen_last[1] = 'hAAAA;
   endtask

   // Random captures: mostly periods near the target with a drifting bias
   task automatic queue_random(int count);
      capture_type c;
      int          roll;
      int          eff_div;
      int          span;
      int          period;
      bit          bias_up;
      bit          go_up;
      @(negedge clock);
      bias_up = 1'b0;
      for (int k = 0; k < count; k++) begin
         if ((k % 16) == 0)
            bias_up = 1'($urandom_range(0, 1));
         roll = $urandom_range(0, 99);
         c.tread       = 1'($urandom_range(0, 1));
         c.drain_first = (k == count / 2);
         if (roll < 4) begin
            c.opcode    = OP_START;
            c.edge_time = TIMER_BITS'($urandom_range(0, 65535));
         end else begin
            c.opcode = OP_EDGE;
            if (roll < 18) begin
               c.edge_time = TIMER_BITS'($urandom_range(0, 65535));
            end else begin
               eff_div = c.tread ? right_div : left_div;
               if (eff_div == 0)
                  eff_div = 1;
               span = eff_div * $urandom_range(0, 200);
               if (span > 70000 || span < 0)
                  span = $urandom_range(0, 70000);
               go_up  = bias_up ^ ($urandom_range(0, 9) >= 7);
               period = go_up ? target_period + span : target_period - span;
               c.edge_time = TIMER_BITS'(gen_last[c.tread] + period);
            end
            gen_last[c.tread] = int'(c.edge_time);
         end
         capture_queue.push_back(c);
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = REG_DESIRED;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.opcode    = OP_START;
      req_chan.tread     = 1'b0;
      req_chan.edge_time = '0;
      rsp_chan.ready     = 1'b0;
      error_count        = 0;
      run_cycles         = 0;
      target_period      = int'(DESIRED_RESET);
      left_div           = int'(DIVISOR_RESET);
      right_div          = int'(DIVISOR_RESET);
      first_pending[0]   = 1'b1;
      first_pending[1]   = 1'b1;
      last_capture[0]    = '0;
      last_capture[1]    = '0;
      duty_now[0]        = DUTY_RESET;
      duty_now[1]        = DUTY_RESET;
      gen_last[0]        = 0;
      gen_last[1]        = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_config(int'(DESIRED_RESET), int'(DIVISOR_RESET), int'(DIVISOR_RESET));
      queue_directed();
      wait_drained();

      // extreme and random register settings, one random phase each
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: write_config(32767, 1, 1);
            1: write_config(0, 32767, 0);
            2: write_config(1200, 8, 300);
            3: write_config($urandom_range(0, 32767), $urandom_range(1, 64),
                            $urandom_range(1, 64));
            default: write_config($urandom_range(0, 32767), $urandom_range(0, 600),
                                  $urandom_range(0, 600));
         endcase
         queue_random(PHASE_ITEMS);
         wait_drained();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
